// ----- src/ipm_pkg.sv -----
package ipm_pkg;

   localparam int SRC_ROWS_DEF = 240;
   localparam int SRC_COLS_DEF = 640;

   localparam int FRAC_BITS = 16;
   localparam int DIV_WIDTH = 64;

   localparam logic signed [63:0] ROW_BASE = 64'sd500;
   localparam logic signed [63:0] ROW_SCALE = 64'sd50;
   localparam logic signed [63:0] COL_BASE = 64'sd150;
   localparam logic signed [63:0] COL_SCALE = 64'sd50;

   // reciprocal of the column scale, exact for any 32-bit dividend
   localparam logic [31:0] DIV50_MUL = 32'h51eb851f;
   localparam int DIV50_SHIFT = 36;

   localparam logic [1:0] CLASS_LOW = 2'd0;
   localparam logic [1:0] CLASS_HIGH = 2'd1;
   localparam logic [1:0] CLASS_OUTSIDE = 2'd2;

   localparam logic [3:0] CSR_H_SIN_PHI = 4'd0;
   localparam logic [3:0] CSR_COS_PHI = 4'd1;
   localparam logic [3:0] CSR_F_H_COS_PHI = 4'd2;
   localparam logic [3:0] CSR_F_SIN_PHI = 4'd3;
   localparam logic [3:0] CSR_FOCAL_LENGTH = 4'd4;
   localparam logic [3:0] CSR_THRESHOLD = 4'd5;
   localparam logic [3:0] CSR_CENTER_X = 4'd6;
   localparam logic [3:0] CSR_CENTER_Y = 4'd7;

   typedef struct packed {
      logic                        start;
      logic signed [DIV_WIDTH-1:0] num;
      logic signed [DIV_WIDTH-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                        done;
      logic signed [DIV_WIDTH-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // truncating divide by a power of two
   function automatic logic signed [63:0] tdiv_pow2(input logic signed [63:0] v,
                                                    input int unsigned k);
      logic signed [63:0] bias;
      bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
      return (v + bias) >>> k;
   endfunction

endpackage

// ----- src/inverse_perspective_remap_top.sv -----
// channel   dir  handshake                 payload
// req       in   req_tvalid/req_tready     tuser kind, tdata write or cell request
// rsp       out  rsp_tvalid/rsp_tready     tuser class, tdata sampled pixel
// csr       in   csr_valid/csr_ready       csr_index, csr_data
// a pixel write is taken only in idle; a cell request runs three divisions one after
// another on the shared radix-2 divider, and the next request is taken once its result
// has moved to the output register; outside exits are shorter
// reset clears control state and sets the csr registers to defaults; image memory is undefined until written
// a finished result waits in the output register while the next request is taken

module inverse_perspective_remap_top
   import ipm_pkg::*;
#(
   parameter int SRC_ROWS = SRC_ROWS_DEF,
   parameter int SRC_COLS = SRC_COLS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,  // kind
   input  logic [47:0] req_tdata,  // src_row, src_col, pixel_value, out_row, out_col
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,  // cell_class
   output logic [7:0]  rsp_tdata,  // ipm_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int DEPTH = SRC_ROWS * SRC_COLS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW = $clog2(SRC_ROWS + 1);
   localparam int CW = $clog2(SRC_COLS + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_YSET, ST_YDIV, ST_YWAIT, ST_YIMG, ST_ZMUL, ST_ZSET, ST_ZDIV,
      ST_ZWAIT, ST_XMUL, ST_XQUO, ST_XREM, ST_XRDIV, ST_XNSUM, ST_XSET, ST_XWAIT,
      ST_XIMG, ST_ADDR, ST_RD, ST_RDW, ST_DONE
   } state_type;

   state_type state_ff;

   logic signed [31:0] h_sin_ff, f_h_cos_ff, f_sin_ff;
   logic signed [17:0] cos_ff;
   logic [30:0]        focal_ff;
   logic [7:0]         thresh_ff;
   logic [25:0]        cx_ff;
   logic [24:0]        cy_ff;

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;
   logic [AW-1:0] rd_addr_ff;

   logic [8:0] row_ff, col_ff;
   logic signed [63:0] n_ff, d_ff, p1_ff, p2_ff;
   logic signed [31:0] yc_ff, zw_ff, xc_ff;
   logic [RW-1:0] yimg_ff;
   logic [CW-1:0] ximg_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_value_ff;
   logic [1:0] rsp_class_ff;
   logic [7:0] res_value_ff;
   logic [1:0] res_class_ff;

   div_req_type div_req_ff;
   div_rsp_type div_rsp;

   logic [7:0] w_row;
   logic [9:0] w_col;
   logic [7:0] w_pix;
   logic       req_fire;
   logic       wr_en;
   logic [AW-1:0] wr_addr;
   logic signed [63:0] dr, dc, dc_mag, yimg, xi, ximg;
   logic signed [63:0] cx64, cy64;
   logic [25:0] fq;

   ipm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   always_comb begin
      w_row = req_tdata[7:0];
      w_col = req_tdata[17:8];
      w_pix = req_tdata[25:18];
      req_fire = req_tvalid && req_tready;
      wr_en = req_fire && !req_tuser[0] && (int'(w_row) < SRC_ROWS)
              && (int'(w_col) < SRC_COLS);
      wr_addr = AW'(int'(w_row) * SRC_COLS + int'(w_col));
      dr = $signed({55'd0, row_ff}) - ROW_BASE;
      dc = $signed({55'd0, col_ff}) - COL_BASE;
      dc_mag = dc[63] ? -dc : dc;
      fq = 26'(p1_ff >>> DIV50_SHIFT);
      cx64 = $signed({38'd0, cx_ff});
      cy64 = $signed({39'd0, cy_ff});
      yimg = tdiv_pow2(cy64 - 64'(yc_ff), FRAC_BITS + 1);
      xi = tdiv_pow2(64'(xc_ff), FRAC_BITS);
      ximg = tdiv_pow2(cx64 - (xi <<< FRAC_BITS), FRAC_BITS);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_value_ff;
   assign rsp_tuser = rsp_class_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= w_pix;
      end
      if (state_ff == ST_RD) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_sin_ff <= '0;
         cos_ff <= 18'sd65536;
         f_h_cos_ff <= '0;
         f_sin_ff <= '0;
         focal_ff <= '0;
         thresh_ff <= 8'd128;
         cx_ff <= 26'd20971520;
         cy_ff <= 25'd15728640;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_H_SIN_PHI:    h_sin_ff <= csr_data;
            CSR_COS_PHI:      cos_ff <= csr_data[17:0];
            CSR_F_H_COS_PHI:  f_h_cos_ff <= csr_data;
            CSR_F_SIN_PHI:    f_sin_ff <= csr_data;
            CSR_FOCAL_LENGTH: focal_ff <= csr_data[30:0];
            CSR_THRESHOLD:    thresh_ff <= csr_data[7:0];
            CSR_CENTER_X:     cx_ff <= csr_data[25:0];
            CSR_CENTER_Y:     cy_ff <= csr_data[24:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         div_req_ff.start <= ((state_ff == ST_YDIV) || (state_ff == ST_ZDIV)
                              || (state_ff == ST_XSET)) && (d_ff != 64'sd0);
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_tuser[0]) begin
                  row_ff <= req_tdata[34:26];
                  col_ff <= req_tdata[43:35];
                  state_ff <= ST_YSET;
               end
            end
            ST_YSET: begin
               n_ff <= ROW_SCALE * 64'(f_h_cos_ff) + dr * 64'(f_sin_ff);
               d_ff <= dr * 64'(cos_ff) - ROW_SCALE * 64'(h_sin_ff);
               state_ff <= ST_YDIV;
            end
            ST_YDIV: begin
               if (d_ff == 64'sd0) begin
                  res_value_ff <= '0;
                  res_class_ff <= CLASS_OUTSIDE;
                  state_ff <= ST_DONE;
               end else begin
                  div_req_ff.num <= n_ff <<< FRAC_BITS;
                  div_req_ff.den <= d_ff;
                  state_ff <= ST_YWAIT;
               end
            end
            ST_YWAIT: begin
               if (div_rsp.done) begin
                  yc_ff <= sat32(div_rsp.quot);
                  state_ff <= ST_YIMG;
               end
            end
            ST_YIMG: begin
               if (!yimg[63] && (yimg < 64'(SRC_ROWS))) begin
                  yimg_ff <= RW'(yimg);
                  state_ff <= ST_ZMUL;
               end else begin
                  res_value_ff <= '0;
                  res_class_ff <= CLASS_OUTSIDE;
                  state_ff <= ST_DONE;
               end
            end
            ST_ZMUL: begin
               p1_ff <= 64'(yc_ff) * 64'(h_sin_ff);
               p2_ff <= 64'(yc_ff) * 64'(cos_ff);
               state_ff <= ST_ZSET;
            end
            ST_ZSET: begin
               n_ff <= 64'(sat32(tdiv_pow2(p1_ff, FRAC_BITS))) + 64'(f_h_cos_ff);
               d_ff <= 64'(f_sin_ff) - 64'(sat32(tdiv_pow2(p2_ff, FRAC_BITS)));
               state_ff <= ST_ZDIV;
            end
            ST_ZDIV: begin
               if (d_ff == 64'sd0) begin
                  res_value_ff <= '0;
                  res_class_ff <= CLASS_OUTSIDE;
                  state_ff <= ST_DONE;
               end else begin
                  div_req_ff.num <= n_ff <<< FRAC_BITS;
                  div_req_ff.den <= d_ff;
                  state_ff <= ST_ZWAIT;
               end
            end
            ST_ZWAIT: begin
               if (div_rsp.done) begin
                  zw_ff <= sat32(div_rsp.quot);
                  state_ff <= ST_XMUL;
               end
            end
            ST_XMUL: begin
               // focal length split by the column scale
               p1_ff <= $signed({33'd0, focal_ff} * DIV50_MUL);
               p2_ff <= 64'(zw_ff) * 64'(cos_ff);
               state_ff <= ST_XQUO;
            end
            ST_XQUO: begin
               n_ff <= $signed({38'd0, fq}) * dc;
               d_ff <= $signed({33'd0, focal_ff}) - $signed({38'd0, fq}) * COL_SCALE;
               state_ff <= ST_XREM;
            end
            ST_XREM: begin
               p1_ff <= d_ff * dc_mag;
               state_ff <= ST_XRDIV;
            end
            ST_XRDIV: begin
               p1_ff <= $signed({32'd0, p1_ff[31:0]} * DIV50_MUL);
               state_ff <= ST_XNSUM;
            end
            ST_XNSUM: begin
               n_ff <= dc[63] ? (-n_ff + (p1_ff >>> DIV50_SHIFT))
                              : (-n_ff - (p1_ff >>> DIV50_SHIFT));
               d_ff <= 64'(h_sin_ff) + 64'(sat32(tdiv_pow2(p2_ff, FRAC_BITS)));
               state_ff <= ST_XSET;
            end
            ST_XSET: begin
               if (d_ff == 64'sd0) begin
                  res_value_ff <= '0;
                  res_class_ff <= CLASS_OUTSIDE;
                  state_ff <= ST_DONE;
               end else begin
                  div_req_ff.num <= n_ff <<< FRAC_BITS;
                  div_req_ff.den <= d_ff;
                  state_ff <= ST_XWAIT;
               end
            end
            ST_XWAIT: begin
               if (div_rsp.done) begin
                  xc_ff <= sat32(div_rsp.quot);
                  state_ff <= ST_XIMG;
               end
            end
            ST_XIMG: begin
               if (!ximg[63] && (ximg < 64'(SRC_COLS))) begin
                  ximg_ff <= CW'(ximg);
                  state_ff <= ST_ADDR;
               end else begin
                  res_value_ff <= '0;
                  res_class_ff <= CLASS_OUTSIDE;
                  state_ff <= ST_DONE;
               end
            end
            ST_ADDR: begin
               rd_addr_ff <= AW'(int'(yimg_ff) * SRC_COLS + int'(ximg_ff));
               state_ff <= ST_RD;
            end
            ST_RD: begin
               state_ff <= ST_RDW;
            end
            ST_RDW: begin
               res_value_ff <= rd_data_ff;
               res_class_ff <= (rd_data_ff > thresh_ff) ? CLASS_HIGH : CLASS_LOW;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= res_value_ff;
                  rsp_class_ff <= res_class_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result shown outside done state");
   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3))
      else $error("bad cell class");
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == CLASS_OUTSIDE) |-> (rsp_tdata == 8'd0))
      else $error("outside cell with nonzero value");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_req_ff.start)
      else $error("request taken while divider starts");
`endif

endmodule

// ----- src/ipm_div.sv -----
module ipm_div
   import ipm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CW = $clog2(DIV_WIDTH + 1);

   logic                 busy_ff;
   logic                 neg_ff;
   logic [CW-1:0]        cnt_ff;
   logic [DIV_WIDTH-1:0] rem_ff;
   logic [DIV_WIDTH-1:0] quo_ff;
   logic [DIV_WIDTH-1:0] den_ff;
   logic                 done_ff;
   logic signed [DIV_WIDTH-1:0] quot_ff;

   logic [DIV_WIDTH:0]   trial_in;
   logic [DIV_WIDTH:0]   shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_WIDTH-1]};
      trial_in = shifted - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= CW'(DIV_WIDTH);
            neg_ff <= div_req.num[DIV_WIDTH-1] ^ div_req.den[DIV_WIDTH-1];
            quo_ff <= div_req.num[DIV_WIDTH-1] ? -div_req.num : div_req.num;
            den_ff <= div_req.den[DIV_WIDTH-1] ? -div_req.den : div_req.den;
            rem_ff <= '0;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - CW'(1);
               if (!trial_in[DIV_WIDTH]) begin
                  rem_ff <= trial_in[DIV_WIDTH-1:0];
                  quo_ff <= {quo_ff[DIV_WIDTH-2:0], 1'b1};
               end else begin
                  rem_ff <= shifted[DIV_WIDTH-1:0];
                  quo_ff <= {quo_ff[DIV_WIDTH-2:0], 1'b0};
               end
            end else begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

// ----- dv/testbench.sv -----
module testbench;
   import ipm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_ROWS = 240;
   localparam int N_COLS = 640;
   localparam int STALL_LIMIT = 6000;
   localparam int SETTLE_CYCLES = 400;

   typedef struct {
      logic        kind;
      logic [47:0] data;
   } req_item_type;

   typedef struct {
      logic [7:0] value;
      logic [1:0] cls;
   } cell_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [0:0]  req_tuser;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;
   logic [7:0]  rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [3:0]  csr_index;
   logic [31:0] csr_data;

   req_item_type req_q[$];
   cell_type     cell_q[$];

   // remap geometry and image as the block should hold them
   longint      geo_h, geo_c, geo_f, geo_s, geo_focal, geo_cx, geo_cy;
   int          geo_thr;
   logic [7:0]  image_mem [N_ROWS*N_COLS];
   bit          image_set [N_ROWS*N_COLS];

   bit          idle_on;
   bit          req_fire, rsp_fire, csr_fire;
   int          req_gap, rsp_gap, quiet_cycles, errors;
   int          n_writes, n_cells, n_inside, n_outside, n_phases;

   inverse_perspective_remap_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // returns image address sampled by the cell, or -1 when outside
   function automatic int cell_address(int r, int c);
      longint dr, yn, yd, yc, yimg, zn, zd, zw, xn, xd, xc, ximg;
      dr = r - 500;
      yn = 50 * geo_f + dr * geo_s;
      yd = dr * geo_c - 50 * geo_h;
      if (yd == 0) return -1;
      yc = clamp32((yn * 65536) / yd);
      yimg = (geo_cy - yc) / 131072;
      if (yimg < 0 || yimg >= N_ROWS) return -1;
      zn = clamp32((yc * geo_h) / 65536) + geo_f;
      zd = geo_s - clamp32((yc * geo_c) / 65536);
      if (zd == 0) return -1;
      zw = clamp32((zn * 65536) / zd);
      xn = (-(geo_focal * (c - 150))) / 50;
      xd = geo_h + clamp32((zw * geo_c) / 65536);
      if (xd == 0) return -1;
      xc = clamp32((xn * 65536) / xd);
      ximg = (geo_cx - (xc / 65536) * 65536) / 65536;
      if (ximg < 0 || ximg >= N_COLS) return -1;
      return int'(yimg) * N_COLS + int'(ximg);
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(99);
      if (!idle_on || p < 65) return 0;
      if (p < 95) return $urandom_range(3, 1);
      return $urandom_range(150, 20);
   endfunction

   task automatic add_write(int row, int col, int pix);
      req_item_type it;
      it.kind = 1'b0;
      it.data = {4'b0, 9'd0, 9'd0, pix[7:0], col[9:0], row[7:0]};
      if (row < N_ROWS && col < N_COLS) begin
         image_mem[row*N_COLS + col] = pix[7:0];
         image_set[row*N_COLS + col] = 1'b1;
      end
      req_q.push_back(it);
      n_writes++;
   endtask

   task automatic add_cell(int r, int c);
      req_item_type it;
      cell_type     exp_cell;
      int           addr;
      addr = cell_address(r, c);
      if (addr >= 0 && !image_set[addr])
         add_write(addr / N_COLS, addr % N_COLS, $urandom_range(255));
      if (addr < 0) begin
         exp_cell.value = 8'd0;
         exp_cell.cls = CLASS_OUTSIDE;
         n_outside++;
      end else begin
         exp_cell.value = image_mem[addr];
         exp_cell.cls = (int'(image_mem[addr]) > geo_thr) ? CLASS_HIGH : CLASS_LOW;
         n_inside++;
      end
      it.kind = 1'b1;
      it.data = {4'b0, c[8:0], r[8:0], 8'd0, 10'd0, 8'd0};
      req_q.push_back(it);
      cell_q.push_back(exp_cell);
      n_cells++;
   endtask

   task automatic csr_write(logic [3:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_H_SIN_PHI:    geo_h = longint'($signed(val));
         CSR_COS_PHI:      geo_c = longint'($signed(val[17:0]));
         CSR_F_H_COS_PHI:  geo_f = longint'($signed(val));
         CSR_F_SIN_PHI:    geo_s = longint'($signed(val));
         CSR_FOCAL_LENGTH: geo_focal = longint'(val[30:0]);
         CSR_THRESHOLD:    geo_thr = int'(val[7:0]);
         CSR_CENTER_X:     geo_cx = longint'(val[25:0]);
         CSR_CENTER_Y:     geo_cy = longint'(val[24:0]);
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      wait (req_q.size() == 0 && cell_q.size() == 0 && !req_tvalid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(logic [31:0] h, logic [31:0] c, logic [31:0] f,
                               logic [31:0] s, logic [31:0] fl, logic [31:0] thr,
                               logic [31:0] cx, logic [31:0] cy);
      wait_idle();
      csr_write(CSR_H_SIN_PHI, h);
      csr_write(CSR_COS_PHI, c);
      csr_write(CSR_F_H_COS_PHI, f);
      csr_write(CSR_F_SIN_PHI, s);
      csr_write(CSR_FOCAL_LENGTH, fl);
      csr_write(CSR_THRESHOLD, thr);
      csr_write(CSR_CENTER_X, cx);
      csr_write(CSR_CENTER_Y, cy);
      n_phases++;
   endtask

   // plausible road camera: height, tilt and focal length
   task automatic camera_geometry();
      real hm, phi, fp;
      hm = 1.0 + $urandom_range(2000) / 1000.0;
      phi = 0.02 + $urandom_range(300) / 1000.0;
      fp = 200.0 + $urandom_range(700);
      set_geometry($rtoi(hm * $sin(phi) * 65536.0), $rtoi($cos(phi) * 65536.0),
                   $rtoi(fp * hm * $cos(phi) * 65536.0), $rtoi(fp * $sin(phi) * 65536.0),
                   $rtoi(fp * 65536.0), $urandom_range(255),
                   $urandom_range(400, 240) * 65536 + $urandom_range(65535),
                   $urandom_range(300, 180) * 65536 + $urandom_range(65535));
   endtask

   task automatic random_traffic(int count);
      int p;
      for (int i = 0; i < count; i++) begin
         p = $urandom_range(99);
         if (p < 35)
            add_write($urandom_range(239), $urandom_range(639), $urandom_range(255));
         else if (p < 45)
            add_write($urandom_range(255), $urandom_range(1023), $urandom_range(255));
         else if (p < 90)
            add_cell($urandom_range(449), $urandom_range(299));
         else
            add_cell($urandom_range(511), $urandom_range(511));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      idle_on = 1'b1;
      geo_h = 0;
      geo_c = 65536;
      geo_f = 0;
      geo_s = 0;
      geo_focal = 0;
      geo_thr = 128;
      geo_cx = 20971520;
      geo_cy = 15728640;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: corner writes, ignored writes, grid extremes
      add_write(0, 0, 0);
      add_write(239, 639, 255);
      add_write(240, 0, 17);
      add_write(0, 640, 33);
      add_write(255, 1023, 255);
      add_cell(0, 0);
      add_cell(449, 299);
      add_cell(511, 511);
      add_cell(500, 150);

      camera_geometry();
      add_write(120, 320, 255);
      add_write(120, 321, 0);
      for (int r = 0; r < 450; r += 90) add_cell(r, 150);
      add_cell(449, 0);
      add_cell(449, 299);
      add_cell(0, 511);
      add_cell(511, 0);

      for (int ph = 0; ph < 4; ph++) begin
         idle_on = (ph != 1);
         camera_geometry();
         random_traffic(250);
      end

      // register extremes, centers at the image edges
      set_geometry(32'h8000_0000, 32'h3_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'd0, 32'd41943040, 32'd31457280);
      random_traffic(100);
      set_geometry(32'h7fff_ffff, 32'h1_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'd0, 32'd255, 32'd0, 32'd0);
      random_traffic(100);
      set_geometry($urandom, $urandom_range(131072), $urandom, $urandom,
                   $urandom_range(32'h7fff_ffff), $urandom_range(255),
                   $urandom_range(41943040), $urandom_range(31457280));
      random_traffic(150);
      camera_geometry();
      random_traffic(250);

      wait_idle();
      $display("covered %0d pixel writes and %0d cell requests over %0d register settings",
               n_writes, n_cells, n_phases);
      $display("cells sampled inside the image: %0d, outside: %0d", n_inside, n_outside);
      if (errors == 0) begin
         $display("inverse_perspective_remap_top regression: pass");
      end else begin
         $display("inverse_perspective_remap_top regression: fail");
      end
      $finish;
   end

   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      rsp_fire <= rsp_tvalid && rsp_tready;
      csr_fire <= csr_valid && csr_ready;
   end

   // request driver and result back-pressure
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
               req_tuser <= req_q[0].kind;
               req_tdata <= req_q[0].data;
               req_tvalid <= 1'b1;
               void'(req_q.pop_front());
               req_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(3) == 0) rsp_gap <= pick_gap();
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      cell_type exp_cell;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cell_q.size() == 0) begin
            $display("%0t: unexpected result value %0d class %0d", $realtime,
                     rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_cell = cell_q.pop_front();
            if (rsp_tdata !== exp_cell.value) begin
               $display("%0t: value expected %0d actual %0d", $realtime,
                        exp_cell.value, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== exp_cell.cls) begin
               $display("%0t: class expected %0d actual %0d", $realtime,
                        exp_cell.cls, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (req_fire || rsp_fire || csr_fire) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $realtime, cell_q.size());
         $display("inverse_perspective_remap_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ----- sim.f -----
src/ipm_pkg.sv
src/ipm_div.sv
src/inverse_perspective_remap_top.sv
dv/testbench.sv
